FILE: rtl/waypoint_guidance_setpoints_defines.svh
// Assertion macros for the waypoint guidance setpoint block.
// Depends on nothing; included by the top level, which supplies clk and rst_n.
`ifndef WAYPOINT_GUIDANCE_SETPOINTS_DEFINES_SVH
`define WAYPOINT_GUIDANCE_SETPOINTS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WGS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WGS_ASSERT_NOW(lbl, ante, cons)
`define WGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/wgs_pkg.sv
// Shared constants for the waypoint guidance setpoint block.
// Depends on nothing; used by the square root, CORDIC and top-level modules.
package wgs_pkg;
  localparam int DIFF_W = 25;
  localparam int SQ_W = 50;
  localparam int ROOT_STEPS = 25;
  localparam int SQRT_LAT = ROOT_STEPS + 2;
  localparam int CORDIC_W = 28;
  localparam int ANGLE_W = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd4;

  localparam logic [ANGLE_W-1:0] ATAN_TBL [24] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304,
    24'd652, 24'd326, 24'd163, 24'd81, 24'd41, 24'd20,
    24'd10, 24'd5, 24'd3, 24'd1, 24'd1, 24'd0
  };
endpackage

FILE: rtl/wgs_isqrt.sv
// Pipelined error length: squares, sum, then one root bit per stage.
// Depends on wgs_pkg.
module wgs_isqrt (
  input  logic                                 clk,
  input  logic signed [wgs_pkg::DIFF_W-1:0]    de,
  input  logic signed [wgs_pkg::DIFF_W-1:0]    dn,
  output logic [wgs_pkg::ROOT_STEPS-1:0]       len
);
  import wgs_pkg::*;

  logic signed [SQ_W-1:0] sqe_r, sqn_r;
  logic [SQ_W-1:0] v_r [ROOT_STEPS+1];
  logic [SQ_W-1:0] res_r [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    sqe_r <= de * de;
    sqn_r <= dn * dn;
    v_r[0] <= SQ_W'(sqe_r) + SQ_W'(sqn_r);
    res_r[0] <= '0;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [SQ_W-1:0] trial;
    assign trial = res_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (v_r[k] >= trial) begin
        v_r[k+1] <= v_r[k] - trial;
        res_r[k+1] <= (res_r[k] >> 1) + BIT;
      end else begin
        v_r[k+1] <= v_r[k];
        res_r[k+1] <= res_r[k] >> 1;
      end
    end
  end

  assign len = res_r[ROOT_STEPS][ROOT_STEPS-1:0];
endmodule

FILE: rtl/wgs_cordic.sv
// Pipelined CORDIC vectoring giving the bearing of the error vector.
// Depends on wgs_pkg.
module wgs_cordic #(
  parameter int STAGES = wgs_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic signed [wgs_pkg::DIFF_W-1:0] de,
  input  logic signed [wgs_pkg::DIFF_W-1:0] dn,
  output logic [15:0]                       heading
);
  import wgs_pkg::*;

  logic signed [CORDIC_W-1:0] x_r [STAGES+1];
  logic signed [CORDIC_W-1:0] y_r [STAGES+1];
  logic [ANGLE_W-1:0] z_r [STAGES+1];
  logic [ANGLE_W:0] z_round;

  // Pre-rotate by a half turn when the north error is negative.
  always_ff @(posedge clk) begin
    if (dn < 0) begin
      x_r[0] <= -CORDIC_W'(dn);
      y_r[0] <= -CORDIC_W'(de);
      z_r[0] <= 24'h800000;
    end else begin
      x_r[0] <= CORDIC_W'(dn);
      y_r[0] <= CORDIC_W'(de);
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN_TBL[i];
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN_TBL[i];
      end
    end
  end

  assign z_round = {1'b0, z_r[STAGES]} + (ANGLE_W+1)'(128);
  assign heading = z_round[ANGLE_W-1:8];
endmodule

FILE: rtl/waypoint_guidance_setpoints.sv
// Top level of the proportional waypoint guidance setpoint block.
// Depends on wgs_pkg, wgs_isqrt, wgs_cordic and the assertion macro header.
//
//   channel  handshake            payload
//   input    start / busy         in_target_*, in_position_*, in_*_heading
//   result   out_valid (strobe)   out_speed_command, out_heading_setpoint, ...
//   config   cfg_we               cfg_index, cfg_data
//
// A request is taken at every edge with start high; busy is tied low since the
// pipeline takes one request per cycle. A request passes stage A, the 25 root
// stages of the length pipeline, then stages E, F and G; the bearing CORDIC
// runs alongside and is delayed to line up. Reset clears only the valid chain
// and the configuration registers. The receiver cannot stall, so nothing waits.
`include "waypoint_guidance_setpoints_defines.svh"
module waypoint_guidance_setpoints #(
  parameter int CORDIC_STAGES = wgs_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [23:0]                 in_target_east,
  input  logic signed [23:0]                 in_target_north,
  input  logic signed [23:0]                 in_position_east,
  input  logic signed [23:0]                 in_position_north,
  input  logic signed [15:0]                 in_current_heading,
  input  logic signed [15:0]                 in_held_heading,
  output logic                               out_valid,
  output logic [22:0]                        out_speed_command,
  output logic signed [15:0]                 out_heading_setpoint,
  output logic signed [23:0]                 out_turn_rate_setpoint,
  output logic                               out_far_from_target,
  input  logic                               cfg_we,
  input  logic [wgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wgs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wgs_pkg::*;

  localparam int HDG_DLY = SQRT_LAT - CORDIC_STAGES - 1;

  // Configuration registers.
  logic [15:0] pos_gain_r, hdg_gain_r;
  logic [22:0] max_err_r, prox_r, max_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gain_r <= 16'd256;
      hdg_gain_r <= 16'd256;
      max_err_r <= 23'd2560;
      prox_r <= 23'd512;
      max_speed_r <= 23'd2560;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_GAIN:  pos_gain_r <= cfg_data[15:0];
        REG_HDG_GAIN:  hdg_gain_r <= cfg_data[15:0];
        REG_MAX_ERR:   max_err_r <= cfg_data;
        REG_PROX:      prox_r <= cfg_data;
        REG_MAX_SPEED: max_speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage A: position error.
  logic a_valid_r;
  logic signed [DIFF_W-1:0] a_de_r, a_dn_r;
  logic [15:0] a_cur_r, a_held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else a_valid_r <= start && !busy;
    a_de_r <= DIFF_W'(in_target_east) - DIFF_W'(in_position_east);
    a_dn_r <= DIFF_W'(in_target_north) - DIFF_W'(in_position_north);
    a_cur_r <= in_current_heading;
    a_held_r <= in_held_heading;
  end

  logic [ROOT_STEPS-1:0] len;
  logic [15:0] cordic_hd;

  wgs_isqrt u_isqrt (.clk(clk), .de(a_de_r), .dn(a_dn_r), .len(len));
  wgs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .de(a_de_r), .dn(a_dn_r), .heading(cordic_hd)
  );

  // Side data rides along with the length pipeline.
  logic v_dly_r [SQRT_LAT];
  logic [15:0] cur_dly_r [SQRT_LAT];
  logic [15:0] held_dly_r [SQRT_LAT];
  logic [15:0] hd_dly_r [HDG_DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_LAT; i++) v_dly_r[i] <= 1'b0;
    end else begin
      v_dly_r[0] <= a_valid_r;
      for (int i = 1; i < SQRT_LAT; i++) v_dly_r[i] <= v_dly_r[i-1];
    end
    cur_dly_r[0] <= a_cur_r;
    held_dly_r[0] <= a_held_r;
    for (int i = 1; i < SQRT_LAT; i++) begin
      cur_dly_r[i] <= cur_dly_r[i-1];
      held_dly_r[i] <= held_dly_r[i-1];
    end
    hd_dly_r[0] <= cordic_hd;
    for (int i = 1; i < HDG_DLY; i++) hd_dly_r[i] <= hd_dly_r[i-1];
  end

  // Stage E: clamp the length, decide proximity, form the heading error.
  logic e_valid_r, e_far_r;
  logic [22:0] e_len_r;
  logic [15:0] e_hd_r, e_held_r;
  logic signed [15:0] e_err_r;
  logic [22:0] len_clamped;

  assign len_clamped = (len > {2'b00, max_err_r}) ? max_err_r : len[22:0];

  always_ff @(posedge clk) begin
    if (!rst_n) e_valid_r <= 1'b0;
    else e_valid_r <= v_dly_r[SQRT_LAT-1];
    e_len_r <= len_clamped;
    e_far_r <= len_clamped > prox_r;
    e_hd_r <= hd_dly_r[HDG_DLY-1];
    e_err_r <= hd_dly_r[HDG_DLY-1] - cur_dly_r[SQRT_LAT-1];
    e_held_r <= held_dly_r[SQRT_LAT-1];
  end

  // Stage F: the two gain products.
  logic f_valid_r, f_far_r;
  logic [38:0] f_speed_r;
  logic signed [32:0] f_rate_r;
  logic [15:0] f_hd_r, f_held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_valid_r <= 1'b0;
    else f_valid_r <= e_valid_r;
    f_speed_r <= 39'(pos_gain_r) * 39'(e_len_r);
    f_rate_r <= $signed({17'b0, hdg_gain_r}) * 33'(e_err_r);
    f_far_r <= e_far_r;
    f_hd_r <= e_hd_r;
    f_held_r <= e_held_r;
  end

  // Stage G: speed clamp, scaling and the near-target override.
  logic [30:0] speed_scaled;
  logic [22:0] speed_nxt;
  assign speed_scaled = f_speed_r[38:8];
  assign speed_nxt = (speed_scaled > {8'b0, max_speed_r}) ? max_speed_r : speed_scaled[22:0];

  logic out_valid_r, out_far_r;
  logic [22:0] out_speed_r;
  logic [15:0] out_hd_r;
  logic [23:0] out_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= f_valid_r;
    out_far_r <= f_far_r;
    out_speed_r <= f_far_r ? speed_nxt : '0;
    out_hd_r <= f_far_r ? f_hd_r : f_held_r;
    out_rate_r <= f_far_r ? f_rate_r[31:8] : '0;
  end

  assign out_valid = out_valid_r;
  assign out_far_from_target = out_far_r;
  assign out_speed_command = out_speed_r;
  assign out_heading_setpoint = out_hd_r;
  assign out_turn_rate_setpoint = out_rate_r;

  // A request taken enters the first stage on the next edge.
  `WGS_ASSERT_NEXT(a_accept_enters, start && !busy, a_valid_r)
  // Near target, speed and turn rate are zero.
  `WGS_ASSERT_NOW(a_near_zero, out_valid && !out_far_from_target,
    out_speed_command == 23'd0 && out_turn_rate_setpoint == 24'd0)
  // A far result carries a length above the proximity distance.
  `WGS_ASSERT_NOW(a_far_len, e_valid_r && e_far_r, e_len_r > prox_r)
endmodule
